/* rtl/mfl_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the luminance key function for the median filter.
// No dependencies; every other file of the block imports this package.
package mfl_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WID_W       = 11;
   localparam int HGT_W       = 16;
   localparam int CH_W        = 8;
   localparam int PIX_W       = 3 * CH_W;
   localparam int KEY_W       = 22;
   localparam int SIDE        = 3;
   localparam int TAPS        = SIDE * SIDE;
   localparam int MID_RANK    = TAPS / 2;
   localparam int STEPQ_DEPTH = 4;
   localparam int RSPQ_DEPTH  = 16;

   localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
   localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

   localparam logic [13:0] KEY_RED   = 14'd2126;
   localparam logic [13:0] KEY_GREEN = 14'd7152;
   localparam logic [13:0] KEY_BLUE  = 14'd722;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // One step of the pixel stream as seen by the line stores and window.
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [COL_W-1:0] col;
      logic             emit;
      logic             last;
      logic             x_lo;
      logic             x_hi;
      logic             y_lo;
      logic             y_hi;
   } step_type;

   function automatic logic [KEY_W-1:0] luma_key(input logic [PIX_W-1:0] rgb);
      logic [KEY_W-1:0] r;
      logic [KEY_W-1:0] g;
      logic [KEY_W-1:0] b;
      r = KEY_W'(rgb[PIX_W-1 -: CH_W]) * KEY_W'(KEY_RED);
      g = KEY_W'(rgb[CH_W +: CH_W]) * KEY_W'(KEY_GREEN);
      b = KEY_W'(rgb[CH_W-1:0]) * KEY_W'(KEY_BLUE);
      return r + g + b;
   endfunction

endpackage

/* rtl/mfl_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers, frame geometry and raster counters.
// Turns accepted items into stream steps for the back end. Uses mfl_pkg.
module mfl_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [mfl_pkg::CH_W-1:0]     req_pixel_red,
   input  logic [mfl_pkg::CH_W-1:0]     req_pixel_green,
   input  logic [mfl_pkg::CH_W-1:0]     req_pixel_blue,
   input  logic                         req_filler,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  mfl_pkg::reg_index_type       csr_index,
   input  logic [mfl_pkg::HGT_W-1:0]    csr_data,
   input  logic                         step_full,
   output logic                         step_push,
   output mfl_pkg::step_type            step_data
);
   import mfl_pkg::*;

   logic [WID_W-1:0] width_ff, width_in, fw_ff, fw_in;
   logic [HGT_W-1:0] height_ff, height_in, fh_ff, fh_in;
   logic [COL_W-1:0] col_ff, col_in, ocol_ff, ocol_in;
   logic [HGT_W-1:0] row_ff, row_in, orow_ff, orow_in;
   logic             done_ff, done_in;
   logic [WID_W-1:0] gap_ff, gap_in;

   logic             pad, acc, start, pix_step, done_step, emit;
   logic [WID_W-1:0] w_clamp, fw, col_p1, ocol_p1;
   logic [HGT_W-1:0] fh;
   logic             x_lo, x_hi, y_lo, y_hi;

   assign csr_ready = 1'b1;

   always_comb begin
      // A single-row frame ends one step short of the lead; a pad step fills it.
      pad       = done_ff && (gap_ff != fw_ff + WID_W'(1));
      req_full  = step_full || pad;
      acc       = req_push && !req_full;
      start     = (col_ff == '0) && (row_ff == '0) && !done_ff;
      priority if (width_ff == '0)                 w_clamp = WID_W'(1);
      else if (width_ff > WID_W'(MAX_WIDTH))       w_clamp = WID_W'(MAX_WIDTH);
      else                                         w_clamp = width_ff;
      fw        = start ? w_clamp : fw_ff;
      fh        = start ? ((height_ff == '0) ? HGT_W'(1) : height_ff) : fh_ff;
      pix_step  = acc && !done_ff && !req_filler;
      done_step = (acc && done_ff) || (pad && !step_full);
      step_push = pix_step || done_step;
      emit      = step_push && (gap_ff == fw + WID_W'(1));
      x_lo      = (ocol_ff == '0);
      x_hi      = ({1'b0, ocol_ff} == fw - WID_W'(1));
      y_lo      = (orow_ff == '0);
      y_hi      = (orow_ff == fh - HGT_W'(1));
      col_p1    = {1'b0, col_ff} + WID_W'(1);
      ocol_p1   = {1'b0, ocol_ff} + WID_W'(1);

      step_data.pixel = pix_step ? {req_pixel_red, req_pixel_green, req_pixel_blue} : '0;
      step_data.col   = col_ff;
      step_data.emit  = emit;
      step_data.last  = x_hi && y_hi;
      step_data.x_lo  = x_lo;
      step_data.x_hi  = x_hi;
      step_data.y_lo  = y_lo;
      step_data.y_hi  = y_hi;

      width_in  = width_ff;
      height_in = height_ff;
      fw_in     = fw_ff;
      fh_in     = fh_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      done_in   = done_ff;
      gap_in    = gap_ff;

      if (csr_valid) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_data[WID_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_data;
         endcase
      end

      if (pix_step) begin
         fw_in = fw;
         fh_in = fh;
      end
      if (step_push) begin
         // The stream column keeps running through the flush so line stores stay aligned.
         if (col_p1 == fw) begin
            col_in = '0;
            if (pix_step) begin
               row_in = row_ff + HGT_W'(1);
               if ({1'b0, row_ff} + (HGT_W+1)'(1) == {1'b0, fh}) begin
                  row_in  = '0;
                  done_in = 1'b1;
               end
            end
         end else begin
            col_in = col_p1[COL_W-1:0];
         end
         if (!emit) begin
            gap_in = gap_ff + WID_W'(1);
         end else if (x_hi && y_hi) begin
            col_in  = '0;
            row_in  = '0;
            ocol_in = '0;
            orow_in = '0;
            done_in = 1'b0;
            gap_in  = '0;
         end else if (ocol_p1 == fw) begin
            ocol_in = '0;
            orow_in = orow_ff + HGT_W'(1);
         end else begin
            ocol_in = ocol_p1[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         fw_ff     <= WID_W'(1);
         fh_ff     <= HGT_W'(1);
         col_ff    <= '0;
         row_ff    <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         done_ff   <= 1'b0;
         gap_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         fw_ff     <= fw_in;
         fh_ff     <= fh_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
         done_ff   <= done_in;
         gap_ff    <= gap_in;
      end
   end

endmodule

/* rtl/mfl_stepq.sv */
`timescale 1ns / 1ps
// Short queue of stream steps between the front end and the back end.
// Uses step_type and STEPQ_DEPTH from mfl_pkg.
module mfl_stepq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mfl_pkg::step_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output mfl_pkg::step_type head
);
   import mfl_pkg::*;

   localparam int PTR_W = $clog2(STEPQ_DEPTH);

   step_type         q_ff [STEPQ_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;

   always_comb begin
      full   = (cnt_ff == (PTR_W+1)'(STEPQ_DEPTH));
      valid  = (cnt_ff != '0);
      head   = q_ff[rd_ff];
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* rtl/mfl_back.sv */
`timescale 1ns / 1ps
// Back end: two line stores, the 3x3 window, key ranking and the result queue.
// Takes steps from mfl_stepq; uses types, constants and luma_key from mfl_pkg.
module mfl_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_valid,
   input  mfl_pkg::step_type          step_head,
   output logic                       step_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [mfl_pkg::CH_W-1:0]   rsp_out_red,
   output logic [mfl_pkg::CH_W-1:0]   rsp_out_green,
   output logic [mfl_pkg::CH_W-1:0]   rsp_out_blue,
   output logic                       rsp_frame_end
);
   import mfl_pkg::*;

   localparam int RPTR_W = $clog2(RSPQ_DEPTH);

   typedef struct packed {
      logic emit;
      logic last;
      logic x_lo;
      logic x_hi;
      logic y_lo;
      logic y_hi;
   } meta_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } rsp_type;

   logic [PIX_W-1:0] line1_mem [MAX_WIDTH];
   logic [PIX_W-1:0] line2_mem [MAX_WIDTH];
   logic [PIX_W-1:0] q1_ff, q2_ff, q1d_ff, pix1_ff, pix2_ff;
   logic [COL_W-1:0] col1_ff;
   meta_type         meta0, meta1_ff, meta2_ff, meta3_ff;
   logic             v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [PIX_W-1:0] win_ff [SIDE][SIDE];
   logic [PIX_W-1:0] col4_in [TAPS];
   logic [PIX_W-1:0] col4_ff [TAPS];
   logic [PIX_W-1:0] col5_ff [TAPS];
   logic [KEY_W-1:0] key4_in [TAPS];
   logic [KEY_W-1:0] key4_ff [TAPS];
   logic [TAPS-1:0]  ahead_in [TAPS];
   logic [TAPS-1:0]  ahead_ff [TAPS];
   logic             last4_ff, last5_ff;
   logic [PIX_W-1:0] pick;

   rsp_type           rq_ff [RSPQ_DEPTH];
   logic [RPTR_W-1:0] rwr_ff, rwr_in, rrd_ff, rrd_in;
   logic [RPTR_W:0]   rcnt_ff, rcnt_in, credit_ff, credit_in;
   logic              rsp_take;

   always_comb begin
      meta0.emit = step_head.emit;
      meta0.last = step_head.last;
      meta0.x_lo = step_head.x_lo;
      meta0.x_hi = step_head.x_hi;
      meta0.y_lo = step_head.y_lo;
      meta0.y_hi = step_head.y_hi;
      // Credits count results in flight plus results queued, so the pipeline never stalls.
      step_pop  = step_valid && (credit_ff < (RPTR_W+1)'(RSPQ_DEPTH));
      rsp_empty = (rcnt_ff == '0);
      rsp_take  = rsp_pop && !rsp_empty;
      credit_in = credit_ff + (RPTR_W+1)'(step_pop && step_head.emit)
                  - (RPTR_W+1)'(rsp_take);
      rcnt_in   = rcnt_ff + (RPTR_W+1)'(v5_ff) - (RPTR_W+1)'(rsp_take);
      rwr_in    = v5_ff ? rwr_ff + RPTR_W'(1) : rwr_ff;
      rrd_in    = rsp_take ? rrd_ff + RPTR_W'(1) : rrd_ff;
      {rsp_out_red, rsp_out_green, rsp_out_blue} = rq_ff[rrd_ff].pixel;
      rsp_frame_end = rq_ff[rrd_ff].last;
   end

   // Line stores: each read returns the pixel one row older at the same column.
   always_ff @(posedge clock) begin
      if (step_pop) begin
         q1_ff                     <= line1_mem[step_head.col];
         line1_mem[step_head.col]  <= step_head.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         q2_ff              <= line2_mem[col1_ff];
         line2_mem[col1_ff] <= q1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pix1_ff  <= step_head.pixel;
      col1_ff  <= step_head.col;
      meta1_ff <= meta0;
      pix2_ff  <= pix1_ff;
      q1d_ff   <= q1_ff;
      meta2_ff <= meta1_ff;
      if (v2_ff) begin
         for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE - 1; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
         end
         win_ff[0][SIDE-1] <= q2_ff;
         win_ff[1][SIDE-1] <= q1d_ff;
         win_ff[2][SIDE-1] <= pix2_ff;
         meta3_ff          <= meta2_ff;
      end
   end

   // Taps outside the image read as black with key zero.
   always_comb begin
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            if ((r == 0 && meta3_ff.y_lo) || (r == SIDE - 1 && meta3_ff.y_hi) ||
                (c == 0 && meta3_ff.x_lo) || (c == SIDE - 1 && meta3_ff.x_hi)) begin
               col4_in[r*SIDE+c] = '0;
            end else begin
               col4_in[r*SIDE+c] = win_ff[r][c];
            end
            key4_in[r*SIDE+c] = luma_key(col4_in[r*SIDE+c]);
         end
      end
   end

   // Element j ranks ahead of i on a smaller key, or an equal key earlier in scan order.
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         for (int j = 0; j < TAPS; j++) begin
            ahead_in[i][j] = (key4_ff[j] < key4_ff[i]) ||
                             ((key4_ff[j] == key4_ff[i]) && (j < i));
         end
      end
   end

   always_comb begin
      pick = '0;
      for (int i = 0; i < TAPS; i++) begin
         if ($countones(ahead_ff[i]) == MID_RANK) begin
            pick = pick | col5_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      col4_ff  <= col4_in;
      key4_ff  <= key4_in;
      last4_ff <= meta3_ff.last;
      col5_ff  <= col4_ff;
      ahead_ff <= ahead_in;
      last5_ff <= last4_ff;
      if (v5_ff) begin
         rq_ff[rwr_ff] <= '{pixel: pick, last: last5_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         rwr_ff    <= '0;
         rrd_ff    <= '0;
         rcnt_ff   <= '0;
         credit_ff <= '0;
      end else begin
         v1_ff     <= step_pop;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff && meta2_ff.emit;
         v4_ff     <= v3_ff;
         v5_ff     <= v4_ff;
         rwr_ff    <= rwr_in;
         rrd_ff    <= rrd_in;
         rcnt_ff   <= rcnt_in;
         credit_ff <= credit_in;
      end
   end

endmodule

/* rtl/median_filter_by_luma_unit.sv */
`timescale 1ns / 1ps
// 3x3 median filter ranked by luminance over an RGB raster stream.
// Throughput: one item per clock while req_full does not hold off the input; the result
// for an item passes the step queue and first line store, second line store, window,
// key stage, compare stage and rank select on its way to the result queue. A single-row
// frame costs one extra internal step at its end. Synchronous reset clears counters
// and queues; the line stores are not cleared, and what they hold from before the frame
// reaches only taps that are masked as outside the image.
module median_filter_by_luma_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [mfl_pkg::CH_W-1:0]   req_pixel_red,
   input  logic [mfl_pkg::CH_W-1:0]   req_pixel_green,
   input  logic [mfl_pkg::CH_W-1:0]   req_pixel_blue,
   input  logic                       req_filler,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [mfl_pkg::CH_W-1:0]   rsp_out_red,
   output logic [mfl_pkg::CH_W-1:0]   rsp_out_green,
   output logic [mfl_pkg::CH_W-1:0]   rsp_out_blue,
   output logic                       rsp_frame_end,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  mfl_pkg::reg_index_type     csr_index,
   input  logic [mfl_pkg::HGT_W-1:0]  csr_data
);
   import mfl_pkg::*;

   logic     step_push, step_full, step_pop, step_valid;
   step_type step_data, step_head;

   mfl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .req_filler      (req_filler),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .step_full       (step_full),
      .step_push       (step_push),
      .step_data       (step_data)
   );

   mfl_stepq u_stepq (
      .clock     (clock),
      .reset     (reset),
      .push      (step_push),
      .push_data (step_data),
      .full      (step_full),
      .pop       (step_pop),
      .valid     (step_valid),
      .head      (step_head)
   );

   mfl_back u_back (
      .clock         (clock),
      .reset         (reset),
      .step_valid    (step_valid),
      .step_head     (step_head),
      .step_pop      (step_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end)
   );

   // The front end must never push a step into a full step queue, pad steps included.
   a_stepq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      step_push |-> !step_full)
      else $error("step pushed into a full step queue");

   // The back end only takes a step that is present.
   a_stepq_no_underflow: assert property (@(posedge clock) disable iff (reset)
      step_pop |-> step_valid)
      else $error("step taken from an empty step queue");

   // A full input side while the step queue has room means a pad step is being issued.
   a_pad_progress: assert property (@(posedge clock) disable iff (reset)
      (req_full && !step_full) |-> step_push)
      else $error("input held off without a pad step");

endmodule

/* test/tb_median_filter_by_luma_unit.sv */
`timescale 1ns / 1ps
// Testbench for median_filter_by_luma_unit: drives frames of RGB pixels and fillers
// and checks each median result against a scoreboard that tracks the frame itself.
// Depends on mfl_pkg and the RTL of the block; needs nothing else.

class median_scoreboard;
   typedef struct {
      bit [7:0] r;
      bit [7:0] g;
      bit [7:0] b;
      bit       fe;
   } median_result_type;

   localparam int STORE_SIZE = 2 * mfl_pkg::MAX_WIDTH + 3;

   bit [23:0]         pixel_store[STORE_SIZE];
   int unsigned       reg_width  = 640;
   int unsigned       reg_height = 480;
   int unsigned       in_col, in_row, out_col, out_row;
   int unsigned       frame_w = 1;
   int unsigned       frame_h = 1;
   bit                flushing;
   median_result_type expected_q[$];
   int                errors;
   int                items;

   function void write_reg(mfl_pkg::reg_index_type idx, bit [15:0] value);
      if (idx == mfl_pkg::REG_IMAGE_WIDTH) reg_width = value[10:0];
      else reg_height = value;
   endfunction

   function int unsigned luma(bit [23:0] c);
      return 2126 * c[23:16] + 7152 * c[15:8] + 722 * c[7:0];
   endfunction

   // Ranks the window around the output position and queues the chosen color.
   function void emit_median();
      bit [23:0]         colors[9];
      int unsigned       keys[9];
      bit [23:0]         pick;
      int                x, y, k, rank;
      median_result_type res;
      k = 0;
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            x = int'(out_col) + dx;
            y = int'(out_row) + dy;
            colors[k] = 0;
            if (x >= 0 && y >= 0 && x < int'(frame_w) && y < int'(frame_h))
               colors[k] = pixel_store[(y * int'(frame_w) + x) % STORE_SIZE];
            keys[k] = luma(colors[k]);
            k++;
         end
      end
      pick = 0;
      for (int i = 0; i < 9; i++) begin
         rank = 0;
         for (int j = 0; j < 9; j++)
            if (keys[j] < keys[i] || (keys[j] == keys[i] && j < i)) rank++;
         if (rank == 4) pick = colors[i];
      end
      res.r  = pick[23:16];
      res.g  = pick[15:8];
      res.b  = pick[7:0];
      res.fe = (out_col + 1 == frame_w) && (out_row + 1 == frame_h);
      expected_q = {expected_q, res};
      if (res.fe) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         flushing = 0;
      end else begin
         out_col++;
         if (out_col >= frame_w) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   function void note_input(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit filler);
      int unsigned idx;
      items++;
      if (flushing) begin
         emit_median();
         return;
      end
      if (filler) return;
      if (in_col == 0 && in_row == 0) begin
         frame_w = reg_width == 0 ? 1 : (reg_width > mfl_pkg::MAX_WIDTH ?
                                        mfl_pkg::MAX_WIDTH : reg_width);
         frame_h = reg_height == 0 ? 1 : reg_height;
      end
      idx = in_row * frame_w + in_col;
      pixel_store[idx % STORE_SIZE] = {r, g, b};
      in_col++;
      if (in_col >= frame_w) begin
         in_col = 0;
         in_row++;
         if (in_row >= frame_h) begin
            in_row = 0;
            flushing = 1;
         end
      end
      if (idx + 1 > out_row * frame_w + out_col + frame_w + 1) emit_median();
   endfunction

   task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task check(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit fe);
      median_result_type e;
      if (expected_q.size() == 0) begin
         report($sformatf("unexpected result %h %h %h fe=%b", r, g, b, fe));
         return;
      end
      e = expected_q.pop_front();
      if (r != e.r) report($sformatf("red %h, expected %h", r, e.r));
      if (g != e.g) report($sformatf("green %h, expected %h", g, e.g));
      if (b != e.b) report($sformatf("blue %h, expected %h", b, e.b));
      if (fe != e.fe) report($sformatf("frame_end %b, expected %b", fe, e.fe));
   endtask
endclass

module tb_median_filter_by_luma_unit;
   import mfl_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 12;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_push = 0;
   logic                 req_full;
   logic [CH_W-1:0]      req_pixel_red = 0, req_pixel_green = 0, req_pixel_blue = 0;
   logic                 req_filler = 0;
   logic                 rsp_empty;
   logic                 rsp_pop = 0;
   logic [CH_W-1:0]      rsp_out_red, rsp_out_green, rsp_out_blue;
   logic                 rsp_frame_end;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   reg_index_type        csr_index = REG_IMAGE_WIDTH;
   logic [HGT_W-1:0]     csr_data = 0;

   median_scoreboard sb = new();
   bit no_idle;
   bit hold_request;
   int quiet_cycles;

   median_filter_by_luma_unit dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock)
      if (!reset && rsp_pop && !rsp_empty)
         sb.check(rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end);

   // Receiver: random stalls, plus one long hold-off when asked.
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_pop <= 0;
            repeat (400) @(negedge clock);
         end else begin
            rsp_pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 11);
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit filler);
      if (!no_idle && $urandom_range(99) < 11) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push        <= 1;
      req_pixel_red   <= r;
      req_pixel_green <= g;
      req_pixel_blue  <= b;
      req_filler      <= filler;
      do @(posedge clock); while (req_full);
      sb.note_input(r, g, b, filler);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, bit [15:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   // Sends one random frame, then flush items until its last result is due.
   task automatic run_frame(bit [15:0] width, bit [15:0] height);
      int unsigned w, h;
      wait_drained();
      write_reg(REG_IMAGE_WIDTH, width);
      write_reg(REG_IMAGE_HEIGHT, height);
      w = width[10:0] == 0 ? 1 : (width[10:0] > MAX_WIDTH ? MAX_WIDTH : width[10:0]);
      h = height == 0 ? 1 : height;
      for (int unsigned i = 0; i < w * h; i++) begin
         // A filler in the middle of a frame must be dropped without a result.
         if ($urandom_range(99) < 4)
            send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
         send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      end
      while (sb.flushing)
         send_item(8'($urandom), 8'($urandom), 8'($urandom),
                   $urandom_range(99) >= 20);
   endtask

   initial begin
      bit [23:0] directed[12];
      directed = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                   24'hFFFFFF, 24'h808080, 24'hFFFFFF, 24'h010101, 24'h7F7F7F,
                   24'hFFFFFF, 24'hFFFFFF};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed frame: 4 x 3 with extreme colors, an ignored filler before it
      // and one in the middle, and a dropped pixel among the flush items.
      write_reg(REG_IMAGE_WIDTH, 4);
      write_reg(REG_IMAGE_HEIGHT, 3);
      send_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
      foreach (directed[i]) begin
         if (i == 6) send_item(8'h00, 8'h00, 8'h00, 1'b1);
         send_item(directed[i][23:16], directed[i][15:8], directed[i][7:0], 1'b0);
      end
      send_item(8'hAA, 8'h55, 8'hAA, 1'b0);
      while (sb.flushing) send_item(8'h00, 8'h00, 8'h00, 1'b1);

      // Small geometries: zero width and height, single pixels, rows and columns.
      run_frame(1, 1);
      run_frame(0, 0);
      run_frame(2, 1);
      run_frame(3, 2);
      run_frame(1, 40);

      // Long stretch without idling, then a receiver hold-off that fills the block.
      no_idle = 1;
      run_frame(9, 7);
      no_idle = 0;
      wait_drained();
      hold_request = 1;
      run_frame(16, 16);

      while (sb.items < 500)
         run_frame(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)));

      wait_drained();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

/* files.f */
rtl/mfl_pkg.sv
rtl/mfl_front.sv
rtl/mfl_stepq.sv
rtl/mfl_back.sv
rtl/median_filter_by_luma_unit.sv
test/tb_median_filter_by_luma_unit.sv
